FILE: hdl/u8dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CpW    = 16;
	localparam int unsigned CountW = 16;
	localparam int unsigned StatW  = 3;
	localparam int unsigned PartW  = 10;
	localparam int unsigned PendW  = 2;

	// lead and continuation byte masks and patterns
	localparam logic [ByteW-1:0] ContMask  = 8'hC0;
	localparam logic [ByteW-1:0] ContPat   = 8'h80;
	localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
	localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
	localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
	localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
	localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
	localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;

	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [StatW-1:0] {
		ST_OK       = 3'd0,
		ST_TRUNC    = 3'd1,
		ST_BADCONT  = 3'd2,
		ST_STRAY    = 3'd3,
		ST_FOURBYTE = 3'd4,
		ST_BADLEAD  = 3'd5
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [CpW-1:0]    code_point;
		status_t           status;
		logic              end_of_string;
		logic [CountW-1:0] char_count;
	} result_t;

endpackage

FILE: hdl/u8dec_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_decode
// Per-byte decode step: holds the sequence state and forms the result of the
// byte presented on step.
// ----------------------------------------------------------------------------
module u8dec_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [u8dec_pkg::ByteW-1:0]   in_byte,
	input  logic                          last_byte,
	output u8dec_pkg::result_t            result
);
	import u8dec_pkg::*;

	logic [PartW-1:0]  partial_q, partial_d;
	logic [PendW-1:0]  pending_q, pending_d;
	logic              dropping_q, dropping_d;
	logic [CountW-1:0] count_q, count_d;

	logic [CountW-1:0] count_inc;
	logic              err;
	status_t           err_stat;
	logic              chr;
	logic [CpW-1:0]    chr_cp;

	assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

	always_comb begin
		partial_d  = partial_q;
		pending_d  = pending_q;
		dropping_d = dropping_q;
		count_d    = count_q;
		err        = 1'b0;
		err_stat   = ST_OK;
		chr        = 1'b0;
		chr_cp     = '0;

		if (dropping_q) begin
			if (last_byte) begin
				dropping_d = 1'b0;
				partial_d  = '0;
				pending_d  = '0;
				count_d    = '0;
			end
		end else if (pending_q != '0) begin
			if (last_byte && pending_q > 2'd1) begin
				err      = 1'b1;
				err_stat = ST_TRUNC;
			end else if ((in_byte & ContMask) != ContPat) begin
				err      = 1'b1;
				err_stat = ST_BADCONT;
			end else if (pending_q == 2'd1) begin
				chr    = 1'b1;
				chr_cp = {partial_q, in_byte[5:0]};
			end else begin
				// second byte of a three-byte sequence
				partial_d = {partial_q[3:0], in_byte[5:0]};
				pending_d = 2'd1;
			end
		end else if (!in_byte[7]) begin
			chr    = 1'b1;
			chr_cp = {{(CpW-ByteW){1'b0}}, in_byte};
		end else if ((in_byte & Lead2Mask) == Lead2Pat) begin
			if (last_byte) begin
				err      = 1'b1;
				err_stat = ST_TRUNC;
			end else begin
				partial_d = {5'd0, in_byte[4:0]};
				pending_d = 2'd1;
			end
		end else if ((in_byte & Lead3Mask) == Lead3Pat) begin
			if (last_byte) begin
				err      = 1'b1;
				err_stat = ST_TRUNC;
			end else begin
				partial_d = {6'd0, in_byte[3:0]};
				pending_d = 2'd2;
			end
		end else if ((in_byte & Lead4Mask) == Lead4Pat) begin
			err      = 1'b1;
			err_stat = ST_FOURBYTE;
		end else if ((in_byte & ContMask) == ContPat) begin
			err      = 1'b1;
			err_stat = ST_STRAY;
		end else begin
			err      = 1'b1;
			err_stat = ST_BADLEAD;
		end

		if (err) begin
			partial_d  = '0;
			pending_d  = '0;
			count_d    = '0;
			dropping_d = !last_byte;
		end else if (chr) begin
			partial_d = '0;
			pending_d = '0;
			count_d   = last_byte ? '0 : count_inc;
		end

		result.valid         = err || chr;
		result.code_point    = chr ? chr_cp : '0;
		result.status        = err ? err_stat : ST_OK;
		result.end_of_string = err || last_byte;
		result.char_count    = err ? count_q : count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			pending_q  <= '0;
			dropping_q <= 1'b0;
			count_q    <= '0;
		end else if (step) begin
			partial_q  <= partial_d;
			pending_q  <= pending_d;
			dropping_q <= dropping_d;
			count_q    <= count_d;
		end
	end

	// a three-byte lead is the only way to have two bytes pending
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("bytes pending out of range");

	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dropping_q |-> (pending_q == '0 && count_q == '0))
		else $error("dropping with sequence state left");

	a_err_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.valid && result.status != ST_OK && !last_byte) |=> dropping_q)
		else $error("error before last byte did not start dropping");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_byte) |=> (!dropping_q && pending_q == '0 && count_q == '0))
		else $error("state not cleared after last byte");

endmodule

FILE: hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to 16-bit code point decoder with error reporting.
// ----------------------------------------------------------------------------
// usage:
//   s_axis takes one UTF-8 byte per item in tdata[7:0], tlast marks the last
//   byte of a string. m_axis gives one item per decoded code point or error:
//   tdata[15:0] code point, tdata[31:16] running count in the string,
//   tuser status (0 ok, 1 truncated, 2 bad continuation, 3 stray
//   continuation, 4 four-byte lead, 5 invalid lead), tlast end of string.
//   after an error the rest of that string gives no items.
// timing:
//   one byte per cycle sustained while m_axis_tready is high. an accepted
//   byte is held in the input register and decoded into the output register
//   when that register is empty or its item is taken. the input register
//   and output register each hold one item; the decode step between them is
//   set by the lead byte compare and the count increment.
// reset and stall:
//   arst_n clears the valid flags of both registers and the decoder state,
//   so the first byte after reset starts a new string. when m_axis_tready is
//   low the output item holds, one more byte waits in the input register,
//   then s_axis_tready drops.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] code_point, [31:16] char_count
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	output logic        m_axis_tlast    // end_of_string
);
	import u8dec_pkg::*;

	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              last_s1;
	logic              valid_s2;
	logic [CpW-1:0]    cp_s2;
	logic [CountW-1:0] count_s2;
	status_t           status_s2;
	logic              eos_s2;
	logic              advance;
	result_t           res;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	u8dec_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			cp_s2     <= res.code_point;
			count_s2  <= res.char_count;
			status_s2 <= res.status;
			eos_s2    <= res.end_of_string;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {count_s2, cp_s2};
	assign m_axis_tuser  = status_s2;
	assign m_axis_tlast  = eos_s2;

	a_err_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != ST_OK) |-> (eos_s2 && cp_s2 == '0))
		else $error("error item without end of string or with data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |-> !advance)
		else $error("decode step while output is stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (m_axis_tuser <= 3'd5))
		else $error("status code out of range");

endmodule

FILE: sim/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking bench for the streaming UTF-8 decoder: a short directed table,
// then random strings (mostly well-formed, some corrupted, some raw noise)
// under several idle and stall mixes. Every output item is compared with the
// result in its typed table row or with a predictor of the decoder.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;
	import u8dec_pkg::*;

	typedef struct packed {
		logic [CpW-1:0]    code_point;
		status_t           status;
		logic              eos;
		logic [CountW-1:0] count;
	} char_res_t;

	typedef struct packed {
		logic [ByteW-1:0] in_b;
		logic             last_b;
		logic             typed;
		char_res_t        want;
	} dir_row_t;

	localparam char_res_t NoRes = '{16'h0000, ST_OK, 1'b0, 16'd0};

	// typed rows carry a result that is plain to read; the rest go to the predictor
	localparam dir_row_t DirRows [25] = '{
		'{8'h00, 1'b0, 1'b1, '{16'h0000, ST_OK,       1'b0, 16'd1}},
		'{8'h7F, 1'b1, 1'b1, '{16'h007F, ST_OK,       1'b1, 16'd2}},
		'{8'hC2, 1'b1, 1'b1, '{16'h0000, ST_TRUNC,    1'b1, 16'd0}},
		'{8'hE0, 1'b0, 1'b0, NoRes},
		'{8'h80, 1'b1, 1'b1, '{16'h0000, ST_TRUNC,    1'b1, 16'd0}},
		'{8'hDF, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b0, 1'b1, '{16'h07FF, ST_OK,       1'b0, 16'd1}},
		'{8'hEF, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b0, 1'b0, NoRes},
		'{8'hBF, 1'b1, 1'b1, '{16'hFFFF, ST_OK,       1'b1, 16'd2}},
		'{8'hC0, 1'b0, 1'b0, NoRes},
		'{8'h41, 1'b1, 1'b1, '{16'h0000, ST_BADCONT,  1'b1, 16'd0}},
		'{8'h61, 1'b0, 1'b0, NoRes},
		'{8'hE1, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b1, '{16'h0000, ST_BADCONT,  1'b1, 16'd1}},
		'{8'h41, 1'b0, 1'b0, NoRes},
		'{8'h42, 1'b1, 1'b0, NoRes},
		'{8'hE2, 1'b0, 1'b0, NoRes},
		'{8'h41, 1'b1, 1'b1, '{16'h0000, ST_TRUNC,    1'b1, 16'd0}},
		'{8'h80, 1'b1, 1'b1, '{16'h0000, ST_STRAY,    1'b1, 16'd0}},
		'{8'hF0, 1'b0, 1'b1, '{16'h0000, ST_FOURBYTE, 1'b1, 16'd0}},
		'{8'hFF, 1'b1, 1'b0, NoRes},
		'{8'hF8, 1'b1, 1'b1, '{16'h0000, ST_BADLEAD,  1'b1, 16'd0}},
		'{8'hF7, 1'b1, 1'b1, '{16'h0000, ST_FOURBYTE, 1'b1, 16'd0}},
		'{8'hFF, 1'b1, 1'b1, '{16'h0000, ST_BADLEAD,  1'b1, 16'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
	logic        s_axis_tlast = 1'b0; // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [15:0] code_point, [31:16] char_count
	logic [2:0]  m_axis_tuser;        // [2:0] status
	logic        m_axis_tlast;        // end_of_string

	utf8_stream_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state
	logic [PartW-1:0]  part_bits  = '0;
	logic [PendW-1:0]  pend_cnt   = '0;
	logic              skip_rest  = 1'b0;
	logic [CountW-1:0] char_tally = '0;

	char_res_t   expected_chars [$];
	int unsigned err_count = 0;
	int unsigned live_items = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	bit          backpressure_req = 1'b0;
	logic        backpressure_on = 1'b0;

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < 40) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		err_count++;
	endtask

	function automatic void clear_string_state();
		part_bits  = '0;
		pend_cnt   = '0;
		skip_rest  = 1'b0;
		char_tally = '0;
	endfunction

	function automatic bit emit_point(input logic [CpW-1:0] cp, input logic last_b,
			output char_res_t r);
		if (char_tally != CountMax) begin
			char_tally++;
		end
		r = '{cp, ST_OK, last_b, char_tally};
		part_bits = '0;
		pend_cnt  = '0;
		if (last_b) begin
			clear_string_state();
		end
		return 1'b1;
	endfunction

	// an error ends the string at once; without tlast the rest of it is skipped
	function automatic bit fail_string(input status_t st, input logic last_b,
			output char_res_t r);
		r = '{16'h0000, st, 1'b1, char_tally};
		clear_string_state();
		skip_rest = !last_b;
		return 1'b1;
	endfunction

	function automatic bit decode_byte(input logic [ByteW-1:0] in_b, input logic last_b,
			output char_res_t r);
		r = NoRes;
		if (skip_rest) begin
			if (last_b) begin
				clear_string_state();
			end
			return 1'b0;
		end
		if (pend_cnt != 0) begin
			// length is checked before the byte contents
			if (last_b && pend_cnt > 1) begin
				return fail_string(ST_TRUNC, last_b, r);
			end
			if ((in_b & ContMask) != ContPat) begin
				return fail_string(ST_BADCONT, last_b, r);
			end
			if (pend_cnt == 1) begin
				return emit_point({part_bits, in_b[5:0]}, last_b, r);
			end
			part_bits = {part_bits[3:0], in_b[5:0]};
			pend_cnt  = 2'd1;
			return 1'b0;
		end
		if (!in_b[7]) begin
			return emit_point({8'h00, in_b}, last_b, r);
		end
		if ((in_b & Lead2Mask) == Lead2Pat) begin
			if (last_b) begin
				return fail_string(ST_TRUNC, last_b, r);
			end
			part_bits = {5'b0, in_b[4:0]};
			pend_cnt  = 2'd1;
			return 1'b0;
		end
		if ((in_b & Lead3Mask) == Lead3Pat) begin
			if (last_b) begin
				return fail_string(ST_TRUNC, last_b, r);
			end
			part_bits = {6'b0, in_b[3:0]};
			pend_cnt  = 2'd2;
			return 1'b0;
		end
		if ((in_b & Lead4Mask) == Lead4Pat) begin
			return fail_string(ST_FOURBYTE, last_b, r);
		end
		if ((in_b & ContMask) == ContPat) begin
			return fail_string(ST_STRAY, last_b, r);
		end
		return fail_string(ST_BADLEAD, last_b, r);
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_byte(input logic [ByteW-1:0] in_b, input logic last_b,
			input logic typed = 1'b0, input char_res_t want = NoRes);
		char_res_t pred;
		bit        has_res;
		if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= in_b;
		s_axis_tlast  <= last_b;
		do @(posedge clk); while (!s_axis_tready);
		if (!skip_rest) begin
			live_items++;
		end
		has_res = decode_byte(in_b, last_b, pred);
		if (typed) begin
			expected_chars.push_back(want);
		end else if (has_res) begin
			expected_chars.push_back(pred);
		end
	endtask

	// random strings: mostly well-formed, a quarter corrupted, some raw noise
	task automatic run_random(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_items);
		logic [ByteW-1:0] seq [$];
		logic [CpW-1:0]   cp;
		int               pos;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		live_items     = 0;
		while (live_items < n_items) begin
			if ($urandom_range(9, 0) == 0) begin
				send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
			end else begin
				seq.delete();
				repeat ($urandom_range(6, 1)) begin
					cp = 16'($urandom_range(65535, 0));
					case ($urandom_range(2, 0))
						0: seq.push_back({1'b0, cp[6:0]});
						1: begin
							seq.push_back({3'b110, cp[10:6]});
							seq.push_back({2'b10, cp[5:0]});
						end
						default: begin
							seq.push_back({4'b1110, cp[15:12]});
							seq.push_back({2'b10, cp[11:6]});
							seq.push_back({2'b10, cp[5:0]});
						end
					endcase
				end
				if ($urandom_range(3, 0) == 0) begin
					pos = $urandom_range(seq.size() - 1, 0);
					case ($urandom_range(2, 0))
						0: seq[pos] = 8'($urandom_range(255, 0));
						1: seq = seq[0:pos];
						default: seq.insert(pos, 8'($urandom_range(255, 0)));
					endcase
				end
				foreach (seq[i]) begin
					send_byte(seq[i], i == seq.size() - 1);
				end
			end
		end
	endtask

	// long receiver hold-off so the input side fills and stalls
	initial begin
		forever begin
			@(posedge clk);
			if (backpressure_req) begin
				backpressure_req = 1'b0;
				backpressure_on <= 1'b1;
				repeat (200) @(posedge clk);
				backpressure_on <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		char_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected item cp=%h status=%0d count=%0d",
					m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]));
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata[15:0] !== want.code_point) begin
					report_mismatch($sformatf("code_point %h, want %h",
						m_axis_tdata[15:0], want.code_point));
				end
				if (m_axis_tuser !== want.status) begin
					report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
				end
				if (m_axis_tlast !== want.eos) begin
					report_mismatch($sformatf("end_of_string %b, want %b", m_axis_tlast, want.eos));
				end
				if (m_axis_tdata[31:16] !== want.count) begin
					report_mismatch($sformatf("char_count %0d, want %0d",
						m_axis_tdata[31:16], want.count));
				end
			end
		end
		m_axis_tready <= !backpressure_on && ($urandom_range(99, 0) >= sink_stall_pct);
	end

	initial begin
		int unsigned waited;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DirRows[i]) begin
			send_byte(DirRows[i].in_b, DirRows[i].last_b, DirRows[i].typed, DirRows[i].want);
		end

		backpressure_req = 1'b1;
		run_random(0, 0, 300);
		run_random(61, 0, 300);
		run_random(0, 61, 300);
		run_random(8, 8, 300);

		s_axis_tvalid  <= 1'b0;
		sink_stall_pct = 0;
		waited = 0;
		while (expected_chars.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d expected items never arrived", expected_chars.size()));
		end
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/u8dec_pkg.sv
hdl/u8dec_decode.sv
hdl/utf8_stream_decoder.sv
sim/tb_utf8_stream_decoder.sv
